// ===== src/bounded_ordered_list_defines.svh =====
// assertion macros for the bounded ordered list
// used by src/bounded_ordered_list.sv; no other dependencies
`ifndef BOUNDED_ORDERED_LIST_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define BOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define BOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/bol_pkg.sv =====
// shared types and constants for the bounded ordered list
// no dependencies; imported by bol_cell, bol_ctrl and bounded_ordered_list
package bol_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int KIND_W      = 3;
    localparam int VALUE_W     = 32;
    localparam int POS_W       = 5;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    localparam logic signed [VALUE_W-1:0] EMPTY_READ = -32'sd1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH   = 3'd0,
        KIND_POP    = 3'd1,
        KIND_APPEND = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_FIND   = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // operation broadcast to every cell, already checked
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH,
        OP_POP,
        OP_APPEND,
        OP_INSERT,
        OP_FIND
    } list_op_t;

    typedef struct packed {
        list_op_t         op;
        logic [POS_W-1:0] pos;
    } cell_cmd_t;

    typedef enum logic {
        S_IDLE,
        S_RESOLVE
    } state_t;

endpackage

// ===== src/bounded_ordered_list.sv =====
// bounded ordered list: one result beat on m_tdata per accepted input beat
// a new beat is not taken while one resolves; the cell row updates on the accepted
// beat and the registered per-cell match flags are or-ed into the result as it loads;
// while a result stalls one more beat is taken and waits; later beats are held off
// reset (rst_n low, asynchronous) empties the list and drops m_tvalid; s_tready is
// high from reset on; entry storage is not cleared and is only read below the count
`include "bounded_ordered_list_defines.svh"

module bounded_ordered_list
    import bol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // item_value[31:0], position[36:32], zero pad
    input  logic [KIND_W-1:0]      s_tuser,   // kind[2:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // read_value[31:0], status[33:32],
                                              // found[34], entry_count[39:35]
);

    localparam int CW = $clog2(DEPTH + 1);

    // input beat unpacking
    logic signed [VALUE_W-1:0] in_value;
    logic [POS_W-1:0]          in_pos;
    logic                      accept;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_pos   = s_tdata[VALUE_W +: POS_W];
    assign accept   = s_tvalid && s_tready;

    // list state and sequencing
    state_t  state_reg;
    state_t  state_next;
    logic    [CW-1:0] count_reg;
    logic    load_out;

    // checker outputs
    cell_cmd_t                 ctrl_cmd;
    cell_cmd_t                 cell_cmd;
    status_t                   ctrl_status;
    logic [CW-1:0]             ctrl_count_next;
    logic signed [VALUE_W-1:0] ctrl_read_value;

    // cell row
    logic signed [VALUE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]          cell_match;

    // result waiting for the match reduction
    logic signed [VALUE_W-1:0] pend_value_reg;
    status_t                   pend_status_reg;
    logic                      pend_find_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    status_t                   out_status_reg;
    logic                      out_found_reg;
    logic [COUNT_W-1:0]        out_count_reg;

    bol_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .kind       (s_tuser),
        .position   (in_pos),
        .count      (count_reg),
        .head_value (cell_value[0]),
        .cmd        (ctrl_cmd),
        .status     (ctrl_status),
        .count_next (ctrl_count_next),
        .read_value (ctrl_read_value)
    );

    // cells only move on an accepted beat
    always_comb
    begin
        cell_cmd = ctrl_cmd;
        if (!accept)
            cell_cmd.op = OP_NONE;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_in;
        logic signed [VALUE_W-1:0] right_in;

        if (i == 0)
        begin : g_first
            assign left_in = in_value;
        end
        else
        begin : g_left
            assign left_in = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = cell_value[i];
        end
        else
        begin : g_right
            assign right_in = cell_value[i+1];
        end

        bol_cell #(
            .DEPTH (DEPTH),
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .cmd         (cell_cmd),
            .count       (count_reg),
            .new_value   (in_value),
            .left_value  (left_in),
            .right_value (right_in),
            .value       (cell_value[i]),
            .match       (cell_match[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_RESOLVE;
            end
            S_RESOLVE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        s_tready = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:    s_tready = 1'b1;
            S_RESOLVE: load_out = !out_valid_reg || m_tready;
            default:   s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                count_reg <= ctrl_count_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_value_reg  <= ctrl_read_value;
            pend_status_reg <= ctrl_status;
            pend_find_reg   <= (s_tuser == KIND_FIND);
        end
        if (load_out)
        begin
            out_value_reg  <= pend_value_reg;
            out_status_reg <= pend_status_reg;
            out_found_reg  <= pend_find_reg && (|cell_match);
            out_count_reg  <= COUNT_W'(count_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, out_found_reg, out_status_reg, out_value_reg};

    // checks on the list control
    `BOL_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH), "count beyond depth")
    `BOL_ASSERT_NEXT(a_accept_resolve, clk, rst_n, accept, state_reg == S_RESOLVE, "beat not resolved")
    `BOL_ASSERT_NEXT(a_count_hold, clk, rst_n, !accept, $stable(count_reg), "count moved without beat")
    `BOL_ASSERT_NEXT(a_no_drop, clk, rst_n, state_reg == S_RESOLVE && m_tvalid && !m_tready, state_reg == S_RESOLVE, "pending result dropped")
    `BOL_ASSERT_IMPL(a_full_status, clk, rst_n, state_reg == S_RESOLVE && pend_status_reg == ST_FULL, count_reg == CW'(DEPTH), "full status on a list with room")

endmodule

// ===== src/bol_cell.sv =====
// one storage cell of the list chain: holds one entry and its match flag
// depends on bol_pkg
module bol_cell
    import bol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int INDEX = 0
)
(
    input  logic                               clk,
    input  cell_cmd_t                          cmd,
    input  logic [$clog2(DEPTH+1)-1:0]         count,
    input  logic signed [VALUE_W-1:0]          new_value,
    input  logic signed [VALUE_W-1:0]          left_value,
    input  logic signed [VALUE_W-1:0]          right_value,
    output logic signed [VALUE_W-1:0]          value,
    output logic                               match
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CMPW-1:0] IDX = CMPW'(INDEX);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;
    logic                      match_reg;
    logic [CMPW-1:0]           count_ext;
    logic [CMPW-1:0]           pos_ext;

    assign count_ext = CMPW'(count);
    assign pos_ext   = CMPW'(cmd.pos);

    always_comb
    begin
        unique case (cmd.op)
            OP_PUSH:   value_next = (IDX == '0) ? new_value : left_value;
            OP_POP:    value_next = right_value;
            OP_APPEND: value_next = (IDX == count_ext) ? new_value : value_reg;
            OP_INSERT:
            begin
                if (IDX == pos_ext)
                    value_next = new_value;
                else if (IDX > pos_ext)
                    value_next = left_value;
                else
                    value_next = value_reg;
            end
            default:   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        // match flag holds until the next operation
        if (cmd.op != OP_NONE)
            match_reg <= (cmd.op == OP_FIND) && (IDX < count_ext) && (value_reg == new_value);
    end

    assign value = value_reg;
    assign match = match_reg;

endmodule

// ===== src/bol_ctrl.sv =====
// operation checker: decides status, cell command, new count and read value
// depends on bol_pkg
module bol_ctrl
    import bol_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic [KIND_W-1:0]                  kind,
    input  logic [POS_W-1:0]                   position,
    input  logic [$clog2(DEPTH+1)-1:0]         count,
    input  logic signed [VALUE_W-1:0]          head_value,
    output cell_cmd_t                          cmd,
    output status_t                            status,
    output logic [$clog2(DEPTH+1)-1:0]         count_next,
    output logic signed [VALUE_W-1:0]          read_value
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    logic             full;
    logic             empty;
    logic [POS_W-1:0] pos_eff;

    assign full    = (count == CW'(DEPTH));
    assign empty   = (count == '0);
    // position zero counts as one
    assign pos_eff = (position == '0) ? POS_W'(1) : position;

    always_comb
    begin
        cmd.op     = OP_NONE;
        cmd.pos    = pos_eff;
        status     = ST_OK;
        count_next = count;
        read_value = '0;
        unique case (kind)
            KIND_PUSH:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.op     = OP_PUSH;
                    count_next = count + CW'(1);
                end
            end
            KIND_POP:
            begin
                if (empty)
                begin
                    status     = ST_EMPTY;
                    read_value = EMPTY_READ;
                end
                else
                begin
                    cmd.op     = OP_POP;
                    read_value = head_value;
                    count_next = count - CW'(1);
                end
            end
            KIND_APPEND:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.op     = OP_APPEND;
                    count_next = count + CW'(1);
                end
            end
            KIND_INSERT:
            begin
                if (empty)
                    status = ST_EMPTY;
                else if (CMPW'(pos_eff) > CMPW'(count))
                    status = ST_RANGE;
                else if (full)
                    status = ST_FULL;
                else
                begin
                    cmd.op     = OP_INSERT;
                    count_next = count + CW'(1);
                end
            end
            KIND_FIND: cmd.op = OP_FIND;
            default:   cmd.op = OP_NONE;
        endcase
    end

endmodule
